// File: rtl/jtm_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jtm_pkg
// Shared constants, codes, types and helpers of the tank motor mixer.
// -----------------------------------------------------------------------------
package jtm_pkg;

  // Percent fixed point
  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned FULL_QF       = 100 << FRACTION_BITS;
  localparam int unsigned QW            = $clog2(FULL_QF + 1);
  localparam int unsigned PCT_W         = 7;
  localparam int unsigned TBL_DEPTH     = 101;

  // Curve builder widths: Q30 values up to 1.0 and their square root radicand
  localparam int unsigned Q30_W = 31;
  localparam int unsigned RAD_W = 61;

  // Configuration channel
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Exact divide by 100 of the boost product through a reciprocal
  localparam int unsigned     BPROD_W = PCT_W + QW;
  localparam int unsigned     BREC_SH = BPROD_W + 7;
  localparam int unsigned     BREC_W  = BREC_SH - 6;
  localparam longint unsigned BREC_M  = ((64'd1 << BREC_SH) + 64'd99) / 64'd100;

  // Exact divide by 25 of the duty quotients through a reciprocal
  localparam int unsigned DIV25_SH = 26;
  localparam logic [21:0] DIV25_M  = 22'd2684355;

  typedef enum logic [1:0] {
    FUNC_JOYSTICK = 2'd0,
    FUNC_TANK     = 2'd1,
    FUNC_STOP     = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE        = 3'd0,
    CFG_EXPO            = 3'd1,
    CFG_MIN_START_LEFT  = 3'd2,
    CFG_MIN_START_RIGHT = 3'd3,
    CFG_SPEED_SCALE     = 3'd4,
    CFG_SIDE_RATIO      = 3'd5,
    CFG_DUTY_LIMIT      = 3'd6
  } cfg_idx_e;

  // Settings for the curve table builder
  typedef struct packed {
    logic          rebuild;
    logic [QW-1:0] deadzone;
    logic [1:0]    expo_int;
    logic [7:0]    expo_frac;
  } shape_cfg_t;

  // Lookup request for both axes
  typedef struct packed {
    logic             en;
    logic [PCT_W-1:0] addr_x;
    logic [PCT_W-1:0] addr_y;
  } shape_req_t;

  // Lookup response and table status
  typedef struct packed {
    logic          ready;
    logic [QW-1:0] mag_x;
    logic [QW-1:0] mag_y;
  } shape_rsp_t;

  // Convert a Q8 register to the percent format, truncating
  function automatic logic [QW-1:0] q8_to_qf(input logic [14:0] r);
    logic [15+FRACTION_BITS-1:0] w;
    w = {r, {FRACTION_BITS{1'b0}}} >> 8;
    return w[QW-1:0];
  endfunction

endpackage

// File: rtl/jtm_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jtm_if
// Valid/ready channels of the mixer: commands, duties and register writes.
// -----------------------------------------------------------------------------
interface jtm_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [7:0] first_percent;
  logic signed [7:0] second_percent;
  modport source (output valid, func, first_percent, second_percent, input ready);
  modport sink   (input valid, func, first_percent, second_percent, output ready);
endinterface

interface jtm_duty_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] left_duty;
  logic signed [16:0] right_duty;
  modport source (output valid, left_duty, right_duty, input ready);
  modport sink   (input valid, left_duty, right_duty, output ready);
endinterface

interface jtm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [jtm_pkg::CFG_IDX_W-1:0]   index;
  logic [jtm_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/jtm_shape_table.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jtm_shape_table
// Deadzone and expo curve per whole percent, built by a bit-serial divider,
// a bit-serial square root and one shared Q30 multiplier; two read ports.
// -----------------------------------------------------------------------------
module jtm_shape_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jtm_pkg::shape_cfg_t  cfg_i,
  input  jtm_pkg::shape_req_t  req_i,
  output jtm_pkg::shape_rsp_t  rsp_o
);

  localparam int unsigned QW  = jtm_pkg::QW;
  localparam int unsigned NW  = jtm_pkg::Q30_W;
  localparam int unsigned RW  = jtm_pkg::RAD_W;
  localparam int unsigned PW  = jtm_pkg::PCT_W;

  typedef enum logic [8:0] {
    G_IDLE  = 9'b000000001,
    G_START = 9'b000000010,
    G_DIV   = 9'b000000100,
    G_POW   = 9'b000001000,
    G_RINIT = 9'b000010000,
    G_ROOT  = 9'b000100000,
    G_RMUL  = 9'b001000000,
    G_SCALE = 9'b010000000,
    G_WRITE = 9'b100000000
  } gen_state_e;

  gen_state_e     state_q, state_d;
  logic [PW-1:0]  idx_q, idx_d;
  logic [QW-1:0]  rem_q, rem_d;
  logic [QW-1:0]  den_q, den_d;
  logic [NW-1:0]  quo_q, quo_d;
  logic [NW-1:0]  n_q, n_d;
  logic [NW-1:0]  c_q, c_d;
  logic [NW-1:0]  r_q, r_d;
  logic [RW-1:0]  rx_q, rx_d;
  logic [RW-1:0]  res_q, res_d;
  logic [RW-1:0]  bit_q, bit_d;
  logic [4:0]     it_q, it_d;
  logic [1:0]     pow_q, pow_d;
  logic [3:0]     k_q, k_d;
  logic [QW-1:0]  wval_q, wval_d;

  logic [QW-1:0]  mem_q [jtm_pkg::TBL_DEPTH];
  logic [QW-1:0]  mag_x_q, mag_y_q;

  logic [QW-1:0]     m_qf;
  logic [QW:0]       rem_sh;
  logic [NW-1:0]     quo_nx;
  logic [QW-1:0]     rem_nx;
  logic [RW:0]       root_t;
  logic [RW-1:0]     res_nx;
  logic [NW-1:0]     mul_b;
  logic [2*NW-1:0]   prod;

  // Shared Q30 multiplier
  always_comb begin
    case (state_q)
      G_POW:   mul_b = n_q;
      G_RMUL:  mul_b = r_q;
      default: mul_b = NW'(100);
    endcase
    prod = (2*NW)'(c_q) * (2*NW)'(mul_b);
  end

  // One restoring divide step
  always_comb begin
    rem_sh = {rem_q, 1'b0};
    if (rem_sh >= {1'b0, den_q}) begin
      rem_nx = QW'(rem_sh - {1'b0, den_q});
      quo_nx = {quo_q[NW-2:0], 1'b1};
    end else begin
      rem_nx = rem_sh[QW-1:0];
      quo_nx = {quo_q[NW-2:0], 1'b0};
    end
  end

  // One square root step
  always_comb begin
    root_t = {1'b0, res_q} + {1'b0, bit_q};
    if ({1'b0, rx_q} >= root_t) begin
      res_nx = (res_q >> 1) + bit_q;
    end else begin
      res_nx = res_q >> 1;
    end
  end

  assign m_qf = QW'({idx_q, {jtm_pkg::FRACTION_BITS{1'b0}}});

  // Sequence the curve for each table entry
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    n_d     = n_q;
    c_d     = c_q;
    r_d     = r_q;
    rx_d    = rx_q;
    res_d   = res_q;
    bit_d   = bit_q;
    it_d    = it_q;
    pow_d   = pow_q;
    k_d     = k_q;
    wval_d  = wval_q;
    case (state_q)
      G_IDLE: begin
      end
      G_START: begin
        if (m_qf <= cfg_i.deadzone) begin
          wval_d  = '0;
          state_d = G_WRITE;
        end else begin
          den_d = QW'(jtm_pkg::FULL_QF) - cfg_i.deadzone;
          if ((m_qf - cfg_i.deadzone) == den_d) begin
            rem_d = '0;
            quo_d = NW'(1);
          end else begin
            rem_d = m_qf - cfg_i.deadzone;
            quo_d = '0;
          end
          it_d    = 5'd29;
          state_d = G_DIV;
        end
      end
      G_DIV: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        if (it_q == 5'd0) begin
          n_d   = quo_nx;
          c_d   = quo_nx;
          r_d   = quo_nx;
          k_d   = 4'd1;
          pow_d = cfg_i.expo_int - 2'd1;
          state_d = (cfg_i.expo_int == 2'd1) ? G_RINIT : G_POW;
        end else begin
          it_d = it_q - 5'd1;
        end
      end
      G_POW: begin
        c_d = prod[2*NW-2:30];
        if (pow_q == 2'd1) begin
          state_d = G_RINIT;
        end else begin
          pow_d = pow_q - 2'd1;
        end
      end
      G_RINIT: begin
        rx_d    = {r_q, 30'd0};
        res_d   = '0;
        bit_d   = RW'(1) << (RW - 1);
        it_d    = 5'd30;
        state_d = G_ROOT;
      end
      G_ROOT: begin
        if ({1'b0, rx_q} >= root_t) begin
          rx_d = RW'({1'b0, rx_q} - root_t);
        end
        res_d = res_nx;
        bit_d = bit_q >> 2;
        if (it_q == 5'd0) begin
          r_d     = res_nx[NW-1:0];
          state_d = G_RMUL;
        end else begin
          it_d = it_q - 5'd1;
        end
      end
      G_RMUL: begin
        if (cfg_i.expo_frac[3'(4'd8 - k_q)]) begin
          c_d = prod[2*NW-2:30];
        end
        if (k_q == 4'd8) begin
          state_d = G_SCALE;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = G_RINIT;
        end
      end
      G_SCALE: begin
        wval_d  = QW'(prod >> (30 - jtm_pkg::FRACTION_BITS));
        state_d = G_WRITE;
      end
      G_WRITE: begin
        if (idx_q == PW'(jtm_pkg::TBL_DEPTH - 1)) begin
          state_d = G_IDLE;
        end else begin
          idx_d   = idx_q + PW'(1);
          state_d = G_START;
        end
      end
      default: begin
        state_d = G_START;
        idx_d   = '0;
      end
    endcase
    // Restart the build when a curve setting is written
    if (cfg_i.rebuild) begin
      state_d = G_START;
      idx_d   = '0;
    end
  end

  // Hold sequencer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_START;
      idx_q   <= '0;
      it_q    <= '0;
      pow_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      it_q    <= it_d;
      pow_q   <= pow_d;
      k_q     <= k_d;
    end
  end

  // Advance datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    n_q    <= n_d;
    c_q    <= c_d;
    r_q    <= r_d;
    rx_q   <= rx_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    wval_q <= wval_d;
  end

  // Write finished entries, read both axes on request
  always_ff @(posedge clk_i) begin
    if (state_q == G_WRITE) begin
      mem_q[idx_q] <= wval_q;
    end
    if (req_i.en) begin
      mag_x_q <= mem_q[req_i.addr_x];
      mag_y_q <= mem_q[req_i.addr_y];
    end
  end

  assign rsp_o.ready = (state_q == G_IDLE);
  assign rsp_o.mag_x = mag_x_q;
  assign rsp_o.mag_y = mag_y_q;

endmodule

// File: rtl/joystick_tank_motor_mixer.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// joystick_tank_motor_mixer
// Joystick or tank command to signed left and right PWM duties.
// -----------------------------------------------------------------------------
// One command is taken per clock while the curve table is ready and no stall
// holds stage 0; its duties pass through the stages into the output register.
// Stalls on the duty side back up through the stages without loss, and a
// waiting result does not block commands entering empty stages. The deadzone
// and expo curve comes from a 101-entry table per whole percent. After reset
// and after every write of the deadzone or expo register the table is rebuilt
// while cmd ready stays low, entry by entry (bit-serial divide, eight
// bit-serial square roots and the shared Q30 multiplier). Other register
// writes take effect at once and configuration is accepted at any time.
module joystick_tank_motor_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  jtm_cmd_if.sink     cmd_i,
  jtm_cfg_if.sink     cfg_i,
  jtm_duty_if.source  duty_o
);

  localparam int unsigned QW     = jtm_pkg::QW;
  localparam int unsigned PW     = jtm_pkg::PCT_W;
  localparam int unsigned FB     = jtm_pkg::FRACTION_BITS;
  localparam int unsigned BPW    = jtm_pkg::BPROD_W;
  localparam int unsigned BMUL_W = jtm_pkg::BPROD_W + jtm_pkg::BREC_W;
  localparam int unsigned NSTG   = 9;

  typedef struct packed {
    logic          neg;
    logic [PW-1:0] mag;
  } pct_t;

  // Mixed axis sum to whole clamped percent
  function automatic pct_t to_pct(input logic signed [QW+1:0] s);
    logic [QW+1:0] a;
    logic [QW+1:0] w;
    pct_t          p;
    a = s[QW+1] ? (QW+2)'(-s) : (QW+2)'(s);
    w = a >> FB;
    p.neg = s[QW+1];
    p.mag = (w > (QW+2)'(100)) ? PW'(100) : w[PW-1:0];
    return p;
  endfunction

  // Minimum start boost from the registered product
  function automatic logic [PW-1:0] boost_pct(input logic [BPW-1:0] pr,
                                              input logic [QW-1:0] ms);
    logic [BMUL_W-1:0] m;
    logic [QW:0]       b;
    m = BMUL_W'(pr) * BMUL_W'(jtm_pkg::BREC_M);
    b = {1'b0, ms} + (QW+1)'(m >> jtm_pkg::BREC_SH);
    if (b > (QW+1)'(jtm_pkg::FULL_QF)) begin
      b = (QW+1)'(jtm_pkg::FULL_QF);
    end
    return PW'(b >> FB);
  endfunction

  // Clamp and take the magnitude of a signed input percent
  function automatic pct_t in_pct(input logic signed [7:0] v);
    logic [7:0] a;
    pct_t       p;
    a = v[7] ? (~v + 8'd1) : v;
    p.neg = v[7];
    p.mag = (a > 8'd100) ? PW'(100) : a[PW-1:0];
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [12:0] dz_q;
  logic [9:0]  expo_q;
  logic [14:0] msl_q, msr_q;
  logic [10:0] spd_q;
  logic [11:0] ratio_q;
  logic [15:0] dlim_q;
  logic        cfg_acc;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q    <= '0;
      expo_q  <= 10'd256;
      msl_q   <= '0;
      msr_q   <= '0;
      spd_q   <= 11'd1024;
      ratio_q <= 12'd1024;
      dlim_q  <= 16'd1023;
    end else if (cfg_acc) begin
      case (jtm_pkg::cfg_idx_e'(cfg_i.index))
        jtm_pkg::CFG_DEADZONE:        dz_q    <= cfg_i.data[12:0];
        jtm_pkg::CFG_EXPO:            expo_q  <= cfg_i.data[9:0];
        jtm_pkg::CFG_MIN_START_LEFT:  msl_q   <= cfg_i.data[14:0];
        jtm_pkg::CFG_MIN_START_RIGHT: msr_q   <= cfg_i.data[14:0];
        jtm_pkg::CFG_SPEED_SCALE:     spd_q   <= cfg_i.data[10:0];
        jtm_pkg::CFG_SIDE_RATIO:      ratio_q <= cfg_i.data[11:0];
        jtm_pkg::CFG_DUTY_LIMIT:      dlim_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Clamp registers to their legal ranges
  logic [12:0]   dz_c;
  logic [9:0]    expo_c;
  logic [14:0]   msl_c, msr_c;
  logic [10:0]   spd_c;
  logic [11:0]   ratio_c;
  logic [QW-1:0] msl_qf, msr_qf;

  always_comb begin
    dz_c    = (dz_q > 13'd7680) ? 13'd7680 : dz_q;
    expo_c  = (expo_q < 10'd256) ? 10'd256 : ((expo_q > 10'd768) ? 10'd768 : expo_q);
    msl_c   = (msl_q > 15'd17920) ? 15'd17920 : msl_q;
    msr_c   = (msr_q > 15'd17920) ? 15'd17920 : msr_q;
    spd_c   = (spd_q > 11'd1024) ? 11'd1024 : spd_q;
    ratio_c = (ratio_q < 12'd205) ? 12'd205 : ((ratio_q > 12'd2048) ? 12'd2048 : ratio_q);
    msl_qf  = jtm_pkg::q8_to_qf(msl_c);
    msr_qf  = jtm_pkg::q8_to_qf(msr_c);
  end

  // ---------------------------------------------------------------------------
  // Curve table
  // ---------------------------------------------------------------------------
  jtm_pkg::shape_cfg_t shp_cfg;
  jtm_pkg::shape_req_t shp_req;
  jtm_pkg::shape_rsp_t shp_rsp;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;
  logic            cmd_acc;
  pct_t            in_a, in_b;

  assign shp_cfg.rebuild   = cfg_acc &&
                             (cfg_i.index == jtm_pkg::CFG_DEADZONE ||
                              cfg_i.index == jtm_pkg::CFG_EXPO);
  assign shp_cfg.deadzone  = jtm_pkg::q8_to_qf({2'b00, dz_c});
  assign shp_cfg.expo_int  = expo_c[9:8];
  assign shp_cfg.expo_frac = expo_c[7:0];

  assign in_a = in_pct(cmd_i.first_percent);
  assign in_b = in_pct(cmd_i.second_percent);

  assign shp_req.en     = en[0];
  assign shp_req.addr_x = in_a.mag;
  assign shp_req.addr_y = in_b.mag;

  jtm_shape_table u_shape (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (shp_cfg),
    .req_i  (shp_req),
    .rsp_o  (shp_rsp)
  );

  // ---------------------------------------------------------------------------
  // Pipeline flow: a stage loads when empty or when it moves on
  // ---------------------------------------------------------------------------
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || duty_o.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign cmd_i.ready = en[0] && shp_rsp.ready;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= cmd_acc;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Stage 0: capture command, table read in flight
  logic [1:0] kind0_q;
  pct_t       a0_q, b0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      kind0_q <= cmd_i.func;
      a0_q    <= in_a;
      b0_q    <= in_b;
    end
  end

  // Stage 1: mix, pass or zero percents
  logic                 joy1_q;
  pct_t                 l1_q, r1_q;
  logic                 joy1_d;
  pct_t                 l1_d, r1_d;
  logic signed [QW+1:0] tx_s, ty_s;

  always_comb begin
    tx_s = (QW+2)'(shp_rsp.mag_x);
    ty_s = (QW+2)'(shp_rsp.mag_y);
    if (a0_q.neg) begin
      tx_s = -tx_s;
    end
    if (b0_q.neg) begin
      ty_s = -ty_s;
    end
    case (jtm_pkg::func_e'(kind0_q))
      jtm_pkg::FUNC_JOYSTICK: begin
        joy1_d = 1'b1;
        l1_d   = to_pct(ty_s + tx_s);
        r1_d   = to_pct(ty_s - tx_s);
      end
      jtm_pkg::FUNC_TANK: begin
        joy1_d = 1'b0;
        l1_d   = a0_q;
        r1_d   = b0_q;
      end
      default: begin
        joy1_d = 1'b0;
        l1_d   = '0;
        r1_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      joy1_q <= joy1_d;
      l1_q   <= l1_d;
      r1_q   <= r1_d;
    end
  end

  // Stage 2: minimum start products
  logic           joy2_q;
  pct_t           l2_q, r2_q;
  logic [BPW-1:0] pl2_q, pr2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      joy2_q <= joy1_q;
      l2_q   <= l1_q;
      r2_q   <= r1_q;
      pl2_q  <= BPW'(l1_q.mag) * BPW'(QW'(jtm_pkg::FULL_QF) - msl_qf);
      pr2_q  <= BPW'(r1_q.mag) * BPW'(QW'(jtm_pkg::FULL_QF) - msr_qf);
    end
  end

  // Stage 3: apply boost to nonzero joystick percents
  pct_t l3_q, r3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      l3_q.neg <= l2_q.neg;
      r3_q.neg <= r2_q.neg;
      l3_q.mag <= (joy2_q && l2_q.mag != '0) ? boost_pct(pl2_q, msl_qf) : l2_q.mag;
      r3_q.mag <= (joy2_q && r2_q.mag != '0) ? boost_pct(pr2_q, msr_qf) : r2_q.mag;
    end
  end

  // Stage 4: speed scale
  logic [17:0] ls4_q, rs4_q;
  logic        ln4_q, rn4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      ls4_q <= 18'(l3_q.mag) * 18'(spd_c);
      rs4_q <= 18'(r3_q.mag) * 18'(spd_c);
      ln4_q <= l3_q.neg;
      rn4_q <= r3_q.neg;
    end
  end

  // Stage 5: left by duty limit, right by side ratio
  logic [33:0] ld5_q;
  logic [29:0] rq5_q;
  logic        ln5_q, rn5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ld5_q <= 34'(ls4_q) * 34'(dlim_q);
      rq5_q <= 30'(rs4_q) * 30'(ratio_c);
      ln5_q <= ln4_q;
      rn5_q <= rn4_q;
    end
  end

  // Stage 6: left quotient, right by duty limit
  logic [17:0] lq6_q;
  logic [45:0] rd6_q;
  logic        ln6_q, rn6_q;
  logic [21:0] ly6;
  logic [43:0] lm6;

  always_comb begin
    ly6 = 22'(ld5_q >> 12);
    lm6 = 44'(ly6) * 44'(jtm_pkg::DIV25_M);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      lq6_q <= 18'(lm6 >> jtm_pkg::DIV25_SH);
      rd6_q <= 46'(rq5_q) * 46'(dlim_q);
      ln6_q <= ln5_q;
      rn6_q <= rn5_q;
    end
  end

  // Stage 7: right quotient, saturate left
  logic [15:0] ls7_q;
  logic [19:0] rq7_q;
  logic        ln7_q, rn7_q;
  logic [23:0] ry7;
  logic [45:0] rm7;

  always_comb begin
    ry7 = 24'(rd6_q >> 22);
    rm7 = 46'(ry7) * 46'(jtm_pkg::DIV25_M);
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      rq7_q <= 20'(rm7 >> jtm_pkg::DIV25_SH);
      ls7_q <= (lq6_q > {2'b00, dlim_q}) ? dlim_q : lq6_q[15:0];
      ln7_q <= ln6_q;
      rn7_q <= rn6_q;
    end
  end

  // Stage 8: saturate right, apply signs into the output register
  logic signed [16:0] left_q, right_q;
  logic [15:0]        rs8;

  assign rs8 = (rq7_q > {4'b0000, dlim_q}) ? dlim_q : rq7_q[15:0];

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      left_q  <= ln7_q ? -$signed({1'b0, ls7_q}) : $signed({1'b0, ls7_q});
      right_q <= rn7_q ? -$signed({1'b0, rs8}) : $signed({1'b0, rs8});
    end
  end

  assign duty_o.valid      = vld_q[NSTG-1];
  assign duty_o.left_duty  = left_q;
  assign duty_o.right_duty = right_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_no_cmd_while_building: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !shp_rsp.ready |-> !cmd_i.ready
  ) else $error("command taken while the curve table is being built");

  a_rebuild_blocks_cmd: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cfg_acc && (cfg_i.index == jtm_pkg::CFG_DEADZONE ||
                 cfg_i.index == jtm_pkg::CFG_EXPO)) |=> !cmd_i.ready
  ) else $error("curve write did not start a table rebuild");

  a_out_from_pipe: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(duty_o.valid) |-> $past(vld_q[NSTG-2])
  ) else $error("result appeared without an item in the stage before");
`endif

endmodule
